FILE: sv/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the next
`define FVB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next cycle check failed");

// antecedent implies consequent in the same cycle
`define FVB_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same cycle check failed");

`endif

FILE: sv/fvb_pkg.sv
// types, constants, classification and rounding functions of the blas1 unit
`default_nettype none
package fvb_pkg;

	localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
	localparam logic [30:0] INF_MAG = 31'h7F800000;
	localparam logic [31:0] POS_ZERO = 32'h00000000;

	typedef enum logic [2:0] {
		MODE_FILL  = 3'd0,
		MODE_COPY  = 3'd1,
		MODE_SCALE = 3'd2,
		MODE_ADD   = 3'd3,
		MODE_AXPY  = 3'd4,
		MODE_AXPBY = 3'd5,
		MODE_DOT   = 3'd6,
		MODE_SSQ   = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_COEF_A = 2'd1,
		REG_COEF_B = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] x_elem;
		logic [31:0] y_elem;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value;
		logic        last_out;
	} out_item_t;

	function automatic logic is_nan(input logic [31:0] v);
		return v[30:0] > INF_MAG;
	endfunction

	function automatic logic is_inf(input logic [31:0] v);
		return v[30:0] == INF_MAG;
	endfunction

	function automatic logic is_zero(input logic [31:0] v);
		return v[30:0] == 31'd0;
	endfunction

	// round s * m * 2^e to binary32, nearest even, m nonzero
	function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
		input logic [63:0] m);
		logic [6:0] lz;
		logic [63:0] mn;
		logic signed [11:0] en;
		logic signed [11:0] be;
		logic signed [11:0] sh;
		logic [6:0] sa;
		logic [63:0] kept;
		logic [63:0] mask;
		logic [63:0] rest;
		logic rbit;
		logic [39:0] base;
		logic [39:0] r;
		lz = 7'd0;
		for (int i = 0; i < 64; i++) begin
			if (m[i]) begin
				lz = 7'(63 - i);
			end
		end
		mn = m << lz;
		en = e - $signed({5'b0, lz});
		be = en + 12'sd190;
		if (be >= 12'sd1) begin
			sh = 12'sd40;
			base = 40'(be - 12'sd1) << 23;
		end else begin
			sh = 12'sd41 - be;
			base = '0;
		end
		if (sh >= 12'sd65) begin
			return {s, 31'd0};
		end
		sa = sh[6:0];
		kept = (sh < 12'sd64) ? (mn >> sa) : 64'd0;
		rbit = mn[6'(sa - 7'd1)];
		mask = (64'd1 << (sa - 7'd1)) - 64'd1;
		rest = mn & mask;
		if (rbit && (rest != 64'd0 || kept[0])) begin
			kept = kept + 64'd1;
		end
		r = base + kept[39:0];
		if (r >= {9'd0, INF_MAG}) begin
			return {s, INF_MAG};
		end
		return {s, r[30:0]};
	endfunction

endpackage
`default_nettype wire

FILE: sv/float_vector_blas1_unit.sv
// top level of the streaming binary32 blas level-1 unit
// One element pair is taken per cycle unless elem_stall is high; each pair passes an input
// register, then two multipliers and one adder in a single pass, then a result register.
// The accumulator add of dot and sum-of-squares closes inside that pass, which keeps the rate
// at one item per clock unless stalled. Reductions give one item on the element marked
// last and then return the accumulator to +0. Registers: mode 0x0, coef_a 0x4, coef_b 0x8.
`default_nettype none
`include "assert_macros.svh"
module float_vector_blas1_unit
	import fvb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      psel,
	input  wire logic      penable,
	input  wire logic      pwrite,
	input  wire logic [3:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic     [31:0] prdata,
	output logic            pready,
	input  wire logic       elem_valid,
	output logic            elem_stall,
	input  wire in_item_t   elem,
	output logic            res_valid,
	input  wire logic       res_stall,
	output out_item_t       res
);

	mode_t mode_q;
	logic [31:0] coef_a_q, coef_b_q, acc_q;
	logic valid_s1;
	in_item_t item_s1;
	logic res_valid_q;
	out_item_t res_q;
	logic en, reduce, cfg_wr;
	reg_idx_t idx;
	logic [31:0] m1a, m1b, p1, p2, add_a, add_b, sum;
	logic [31:0] value;

	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (idx)
			REG_MODE:   prdata = {29'd0, mode_q};
			REG_COEF_A: prdata = coef_a_q;
			REG_COEF_B: prdata = coef_b_q;
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FILL;
			coef_a_q <= '0;
			coef_b_q <= '0;
		end else if (cfg_wr) begin
			unique case (idx)
				REG_MODE:   mode_q <= mode_t'(pwdata[2:0]);
				REG_COEF_A: coef_a_q <= pwdata;
				REG_COEF_B: coef_b_q <= pwdata;
				default:    ;
			endcase
		end
	end

	assign en = !(res_valid_q && res_stall);
	assign elem_stall = !en;
	assign reduce = (mode_q == MODE_DOT) || (mode_q == MODE_SSQ);

	// operand selection for the shared multiplier and adder
	always_comb begin
		m1a = reduce ? item_s1.x_elem : coef_a_q;
		m1b = (mode_q == MODE_DOT) ? item_s1.y_elem : item_s1.x_elem;
		add_a = (mode_q == MODE_ADD) ? item_s1.x_elem : (reduce ? acc_q : p1);
		add_b = (mode_q == MODE_AXPBY) ? p2 : (reduce ? p1 : item_s1.y_elem);
	end

	fvb_fmul u_mul_a (.a(m1a), .b(m1b), .p(p1));
	fvb_fmul u_mul_b (.a(coef_b_q), .b(item_s1.y_elem), .p(p2));
	fvb_fadd u_add (.a(add_a), .b(add_b), .sum(sum));

	always_comb begin
		unique case (mode_q)
			MODE_FILL:  value = coef_a_q;
			MODE_COPY:  value = item_s1.x_elem;
			MODE_SCALE: value = p1;
			default:    value = sum;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			acc_q <= POS_ZERO;
		end else if (en) begin
			valid_s1 <= elem_valid;
			res_valid_q <= valid_s1 && (!reduce || item_s1.last);
			if (valid_s1 && reduce) begin
				acc_q <= item_s1.last ? POS_ZERO : sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= elem;
			res_q.value <= value;
			res_q.last_out <= reduce ? 1'b1 : item_s1.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	`FVB_ASSERT_NEXT(a_red_quiet, en && valid_s1 && reduce && !item_s1.last, !res_valid_q)
	`FVB_ASSERT_NEXT(a_acc_clear, en && valid_s1 && reduce && item_s1.last,
		acc_q == POS_ZERO && res_q.last_out)
	`FVB_ASSERT_NEXT(a_elem_out, en && valid_s1 && !reduce, res_valid_q)
	`FVB_ASSERT_SAME(a_stall_src, res_valid_q && res_stall, elem_stall)

endmodule
`default_nettype wire

FILE: sv/fvb_fmul.sv
// binary32 multiplier, round to nearest even
`default_nettype none
module fvb_fmul
	import fvb_pkg::*;
(
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [31:0] p
);

	logic s;
	logic [23:0] ma, mb;
	logic [8:0] ea, eb;
	logic [47:0] prod;
	logic signed [11:0] e;

	always_comb begin
		s = a[31] ^ b[31];
		ma = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
		mb = (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
		ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
		eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
		prod = ma * mb;
		e = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 12'sd300;
		if (is_nan(a) || is_nan(b)) begin
			p = QNAN_BITS;
		end else if (is_inf(a) || is_inf(b)) begin
			p = (is_zero(a) || is_zero(b)) ? QNAN_BITS : {s, INF_MAG};
		end else if (is_zero(a) || is_zero(b)) begin
			p = {s, 31'd0};
		end else begin
			p = round_pack(s, e, {16'd0, prod});
		end
	end

endmodule
`default_nettype wire

FILE: sv/fvb_fadd.sv
// binary32 adder, round to nearest even
`default_nettype none
module fvb_fadd
	import fvb_pkg::*;
(
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [31:0] sum
);

	logic sa, sb, sg, sw;
	logic [23:0] ma0, mb0;
	logic [8:0] ea0, eb0, eh, el, d;
	logic [63:0] mh, ml, lost, m;

	always_comb begin
		ma0 = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
		mb0 = (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
		ea0 = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
		eb0 = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
		sw = eb0 > ea0;
		mh = {40'd0, sw ? mb0 : ma0} << 39;
		ml = {40'd0, sw ? ma0 : mb0} << 39;
		eh = sw ? eb0 : ea0;
		el = sw ? ea0 : eb0;
		sa = sw ? b[31] : a[31];
		sb = sw ? a[31] : b[31];
		d = eh - el;
		lost = '0;
		if (d >= 9'd63) begin
			ml = 64'd1;
		end else if (d != 9'd0) begin
			lost = ml & ((64'd1 << d[5:0]) - 64'd1);
			ml = (ml >> d[5:0]) | {63'd0, lost != 64'd0};
		end
		if (sa == sb) begin
			m = mh + ml;
			sg = sa;
		end else if (mh >= ml) begin
			m = mh - ml;
			sg = sa;
		end else begin
			m = ml - mh;
			sg = sb;
		end
		if (is_nan(a) || is_nan(b)) begin
			sum = QNAN_BITS;
		end else if (is_inf(a) || is_inf(b)) begin
			if (is_inf(a) && is_inf(b) && a[31] != b[31]) begin
				sum = QNAN_BITS;
			end else begin
				sum = is_inf(a) ? a : b;
			end
		end else if (is_zero(a) && is_zero(b)) begin
			sum = {a[31] & b[31], 31'd0};
		end else if (is_zero(a)) begin
			sum = b;
		end else if (is_zero(b)) begin
			sum = a;
		end else if (m == 64'd0) begin
			sum = POS_ZERO;
		end else begin
			sum = round_pack(sg, $signed({3'b0, eh}) - 12'sd189, m);
		end
	end

endmodule
`default_nettype wire
